FILE: hdl/ssnt_pkg.sv
package ssnt_pkg;

    localparam int STEPS = 16;
    localparam int NOTES = 8;
    localparam int STEP_W = $clog2(STEPS);
    localparam int NOTE_W = $clog2(NOTES);
    localparam int CNT_W = $clog2(NOTES + 1);
    localparam int QDEPTH = 2;

    localparam logic [9:0] GATE_MAX = 10'd1000;
    localparam logic [6:0] VEL_MAX = 7'd127;
    localparam logic [6:0] PROB_MAX = 7'd100;
    localparam logic [7:0] CYCLE_DEFAULT = 8'd12;
    localparam int OCT_BASE = 4;
    localparam int OCT_TOP = 9;

    localparam logic [2:0] REG_CYCLE = 3'd0;
    localparam logic [2:0] REG_TRANSPOSE = 3'd1;
    localparam logic [2:0] REG_GATE = 3'd2;
    localparam logic [2:0] REG_VEL = 3'd3;
    localparam logic [2:0] REG_PROB = 3'd4;

    typedef enum logic [3:0] {
        OP_SELECT = 4'd0, OP_DESELECT = 4'd1, OP_RESET = 4'd2, OP_RESET_ALL = 4'd3,
        OP_TOGGLE = 4'd4, OP_CLEAR = 4'd5, OP_COPY = 4'd6, OP_GATE = 4'd7,
        OP_VELOCITY = 4'd8, OP_PROBABILITY = 4'd9, OP_TIE = 4'd10,
        OP_TRANSPOSE = 4'd11, OP_READ = 4'd12
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0, ST_REFUSED = 2'd1, ST_EMPTY = 2'd2, ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [3:0] opcode;
        logic [7:0] step_index;
        logic [7:0] other_step;
        logic signed [15:0] pitch;
        logic signed [15:0] pitch_delta;
        logic [15:0] setting_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic note_valid;
        logic signed [15:0] note_pitch;
        logic [3:0] note_count;
        logic [9:0] gate_out;
        logic [6:0] velocity_out;
        logic [6:0] probability_out;
        logic tie_out;
        logic programmed;
        logic selected_valid;
        logic [3:0] selected_index;
        logic last;
    } out_item_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t op;
        logic op_known;
        logic s_ok;
        logic d_ok;
        logic [STEP_W-1:0] s;
        logic [STEP_W-1:0] d;
        logic signed [15:0] pitch;
        logic signed [15:0] delta;
        logic [9:0] gate_c;
        logic [6:0] vel_c;
        logic [6:0] prob_c;
        logic tie_c;
    } cmd_t;

    typedef struct packed {
        logic [7:0] cycle_length;
        logic signed [15:0] global_transpose;
        logic [9:0] default_gate;
        logic [6:0] default_velocity;
        logic [6:0] default_probability;
    } cfg_t;

endpackage

FILE: hdl/ssnt_front.sv
module ssnt_front (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  ssnt_pkg::in_item_t s_data,
    output logic q_valid,
    input  logic q_ready,
    output ssnt_pkg::cmd_t q_cmd
);

    ssnt_pkg::cmd_t cmd;
    ssnt_pkg::cmd_t fifo_reg [ssnt_pkg::QDEPTH];
    logic wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    always_comb begin
        cmd.op = ssnt_pkg::op_t'(s_data.opcode);
        cmd.op_known = s_data.opcode <= 4'(ssnt_pkg::OP_READ);
        cmd.s_ok = s_data.step_index < 8'(ssnt_pkg::STEPS);
        cmd.d_ok = s_data.other_step < 8'(ssnt_pkg::STEPS);
        cmd.s = s_data.step_index[ssnt_pkg::STEP_W-1:0];
        cmd.d = s_data.other_step[ssnt_pkg::STEP_W-1:0];
        cmd.pitch = s_data.pitch;
        cmd.delta = s_data.pitch_delta;
        cmd.gate_c = (s_data.setting_value > 16'(ssnt_pkg::GATE_MAX)) ?
                     ssnt_pkg::GATE_MAX : s_data.setting_value[9:0];
        cmd.vel_c = (s_data.setting_value > 16'(ssnt_pkg::VEL_MAX)) ?
                    ssnt_pkg::VEL_MAX : s_data.setting_value[6:0];
        cmd.prob_c = (s_data.setting_value > 16'(ssnt_pkg::PROB_MAX)) ?
                     ssnt_pkg::PROB_MAX : s_data.setting_value[6:0];
        cmd.tie_c = s_data.setting_value != 16'd0;
    end

    assign s_ready = cnt_reg != 2'(ssnt_pkg::QDEPTH);
    assign q_valid = cnt_reg != 2'd0;
    assign q_cmd = fifo_reg[rp_reg];
    assign push = s_valid && s_ready;
    assign pop = q_valid && q_ready;

    always_comb begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            fifo_reg[wp_reg] <= cmd;
        end
    end

endmodule

FILE: hdl/ssnt_back.sv
module ssnt_back (
    input  logic aclk,
    input  logic aresetn,
    input  ssnt_pkg::cfg_t cfg,
    input  logic q_valid,
    output logic q_ready,
    input  ssnt_pkg::cmd_t q_cmd,
    output logic m_valid,
    input  logic m_ready,
    output ssnt_pkg::out_item_t m_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_CHECK, S_EXEC, S_EMIT, S_CLEAR
    } state_t;

    state_t state_reg;
    ssnt_pkg::cmd_t cmd_reg;

    // per-step storage, one row per step
    logic signed [15:0] notes_reg [ssnt_pkg::STEPS][ssnt_pkg::NOTES];
    logic [ssnt_pkg::CNT_W-1:0] count_reg [ssnt_pkg::STEPS];
    logic [9:0] gate_reg [ssnt_pkg::STEPS];
    logic [6:0] vel_reg [ssnt_pkg::STEPS];
    logic [6:0] prob_reg [ssnt_pkg::STEPS];
    logic tie_reg [ssnt_pkg::STEPS];
    logic sel_valid_reg;
    logic [ssnt_pkg::STEP_W-1:0] sel_index_reg;

    // working copy of the target row
    logic signed [15:0] row_reg [ssnt_pkg::NOTES];
    logic [ssnt_pkg::CNT_W-1:0] rcnt_reg;
    logic [9:0] rgate_reg;
    logic [6:0] rvel_reg, rprob_reg;
    logic rtie_reg;
    logic [ssnt_pkg::STEP_W-1:0] tgt_reg;
    logic [ssnt_pkg::NOTE_W-1:0] idx_reg;
    logic [ssnt_pkg::STEP_W-1:0] clr_reg;
    logic bad_reg;
    logic [1:0] status_reg;
    logic init_reg;

    logic [9:0] dgate;
    logic [6:0] dprob;
    logic signed [17:0] shifted;
    logic signed [17:0] disp;
    logic signed [8:0] cyc;
    logic signed [17:0] cyc_w;
    logic signed [17:0] oct_lo;
    logic signed [17:0] oct_hi;
    logic note_bad;

    logic signed [15:0] trow [ssnt_pkg::NOTES];
    logic [ssnt_pkg::CNT_W-1:0] tcnt;
    logic tok;
    logic found;
    logic [ssnt_pkg::NOTE_W:0] fpos;

    ssnt_pkg::status_t exec_status;
    ssnt_pkg::out_item_t emit_data;
    logic emit_more;
    logic emit_go;

    assign dgate = (cfg.default_gate > ssnt_pkg::GATE_MAX) ? ssnt_pkg::GATE_MAX
                                                          : cfg.default_gate;
    assign dprob = (cfg.default_probability > ssnt_pkg::PROB_MAX) ? ssnt_pkg::PROB_MAX
                                                                  : cfg.default_probability;
    // m_data holds a waiting result, so the next command may proceed meanwhile
    assign q_ready = (state_reg == S_IDLE) && !init_reg;
    assign emit_go = (state_reg == S_EMIT) && (!m_valid || m_ready);

    // transpose range check of one note per cycle; the displayed octave
    // floor(disp / cyc) + base stays in range exactly when disp lies in
    // [-base * cyc, (top - base + 1) * cyc)
    always_comb begin
        shifted = 18'(row_reg[idx_reg]) + 18'(cmd_reg.delta);
        disp = shifted + 18'(cfg.global_transpose);
        cyc = (cfg.cycle_length == 8'd0) ? 9'(ssnt_pkg::CYCLE_DEFAULT)
                                         : 9'({1'b0, cfg.cycle_length});
        cyc_w = 18'(cyc);
        oct_lo = -(18'(ssnt_pkg::OCT_BASE) * cyc_w);
        oct_hi = 18'(ssnt_pkg::OCT_TOP - ssnt_pkg::OCT_BASE + 1) * cyc_w;
        note_bad = shifted < -18'sd32768 || shifted > 18'sd32767 ||
                   disp < oct_lo || disp >= oct_hi;
    end

    // toggle: remove if present, else sorted insert if the row has room
    always_comb begin
        found = 1'b0;
        fpos = '0;
        for (int k = 0; k < ssnt_pkg::NOTES; k++) begin
            if (!found && (k < int'(rcnt_reg)) && row_reg[k] == cmd_reg.pitch) begin
                found = 1'b1;
                fpos = (ssnt_pkg::NOTE_W+1)'(k);
            end
        end
        tok = 1'b0;
        tcnt = rcnt_reg;
        for (int k = 0; k < ssnt_pkg::NOTES; k++) begin
            trow[k] = row_reg[k];
        end
        if (found) begin
            for (int k = 0; k < ssnt_pkg::NOTES; k++) begin
                if (k >= int'(fpos)) begin
                    trow[k] = (k + 1 < int'(rcnt_reg)) ? row_reg[(k+1) % ssnt_pkg::NOTES]
                                                       : ((k < int'(rcnt_reg)) ? 16'sd0
                                                                               : row_reg[k]);
                end
            end
            tcnt = rcnt_reg - 1'b1;
            tok = 1'b1;
        end else if (int'(rcnt_reg) < ssnt_pkg::NOTES) begin
            for (int k = 0; k < ssnt_pkg::NOTES; k++) begin
                if (k <= int'(rcnt_reg)) begin
                    if (k > 0 && row_reg[(k+ssnt_pkg::NOTES-1) % ssnt_pkg::NOTES] > cmd_reg.pitch)
                    begin
                        trow[k] = row_reg[(k+ssnt_pkg::NOTES-1) % ssnt_pkg::NOTES];
                    end else if (k == 0 || row_reg[(k+ssnt_pkg::NOTES-1) % ssnt_pkg::NOTES]
                                           <= cmd_reg.pitch) begin
                        trow[k] = (k < int'(rcnt_reg) && row_reg[k] <= cmd_reg.pitch) ?
                                  row_reg[k] : cmd_reg.pitch;
                    end
                end
            end
            tcnt = rcnt_reg + 1'b1;
            tok = 1'b1;
        end
    end

    // status of the command being executed
    always_comb begin
        exec_status = ssnt_pkg::ST_REFUSED;
        if (cmd_reg.op_known) begin
            unique case (cmd_reg.op)
                ssnt_pkg::OP_SELECT, ssnt_pkg::OP_RESET, ssnt_pkg::OP_CLEAR,
                ssnt_pkg::OP_READ:
                    if (cmd_reg.s_ok) exec_status = ssnt_pkg::ST_DONE;
                ssnt_pkg::OP_DESELECT, ssnt_pkg::OP_RESET_ALL:
                    exec_status = ssnt_pkg::ST_DONE;
                ssnt_pkg::OP_TOGGLE:
                    if (sel_valid_reg && tok) exec_status = ssnt_pkg::ST_DONE;
                ssnt_pkg::OP_COPY:
                    if (cmd_reg.s_ok && cmd_reg.d_ok) exec_status = ssnt_pkg::ST_DONE;
                ssnt_pkg::OP_GATE:
                    if (cmd_reg.s_ok && rgate_reg != cmd_reg.gate_c)
                        exec_status = ssnt_pkg::ST_DONE;
                ssnt_pkg::OP_VELOCITY:
                    if (cmd_reg.s_ok && rvel_reg != cmd_reg.vel_c)
                        exec_status = ssnt_pkg::ST_DONE;
                ssnt_pkg::OP_PROBABILITY:
                    if (cmd_reg.s_ok && rprob_reg != cmd_reg.prob_c)
                        exec_status = ssnt_pkg::ST_DONE;
                ssnt_pkg::OP_TIE:
                    if (cmd_reg.s_ok && rtie_reg != cmd_reg.tie_c)
                        exec_status = ssnt_pkg::ST_DONE;
                ssnt_pkg::OP_TRANSPOSE: begin
                    if (!cmd_reg.s_ok || rcnt_reg == '0) begin
                        exec_status = ssnt_pkg::ST_EMPTY;
                    end else if (bad_reg) begin
                        exec_status = ssnt_pkg::ST_RANGE;
                    end else if (cmd_reg.delta != 16'sd0) begin
                        exec_status = ssnt_pkg::ST_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    // result word for the current emit cycle
    always_comb begin
        emit_data = '0;
        emit_data.status = status_reg;
        emit_data.selected_valid = sel_valid_reg;
        emit_data.selected_index = 4'(sel_index_reg);
        emit_data.last = 1'b1;
        emit_more = 1'b0;
        if (cmd_reg.op_known && cmd_reg.op == ssnt_pkg::OP_READ) begin
            emit_data.note_valid = rcnt_reg != '0;
            emit_data.note_pitch = (rcnt_reg != '0) ? row_reg[idx_reg] : 16'sd0;
            emit_data.note_count = 4'(rcnt_reg);
            emit_data.gate_out = rgate_reg;
            emit_data.velocity_out = rvel_reg;
            emit_data.probability_out = rprob_reg;
            emit_data.tie_out = rtie_reg;
            emit_data.programmed = (rcnt_reg != '0) || rtie_reg;
            emit_more = 32'(idx_reg) + 1 < 32'(rcnt_reg);
            emit_data.last = !emit_more;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            m_valid <= 1'b0;
            sel_valid_reg <= 1'b0;
            sel_index_reg <= '0;
            clr_reg <= '0;
            init_reg <= 1'b1;
        end else begin
            if (emit_go) begin
                m_valid <= 1'b1;
            end else if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_ready) begin
                        cmd_reg <= q_cmd;
                        tgt_reg <= (q_cmd.op == ssnt_pkg::OP_TOGGLE) ? sel_index_reg : q_cmd.s;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    for (int k = 0; k < ssnt_pkg::NOTES; k++) begin
                        row_reg[k] <= notes_reg[tgt_reg][k];
                    end
                    rcnt_reg <= count_reg[tgt_reg];
                    rgate_reg <= gate_reg[tgt_reg];
                    rvel_reg <= vel_reg[tgt_reg];
                    rprob_reg <= prob_reg[tgt_reg];
                    rtie_reg <= tie_reg[tgt_reg];
                    idx_reg <= '0;
                    bad_reg <= 1'b0;
                    state_reg <= (cmd_reg.op == ssnt_pkg::OP_TRANSPOSE && cmd_reg.s_ok &&
                                  count_reg[tgt_reg] != '0) ? S_CHECK : S_EXEC;
                end
                S_CHECK: begin
                    if (note_bad) begin
                        bad_reg <= 1'b1;
                    end
                    if (32'(idx_reg) + 1 >= 32'(rcnt_reg)) begin
                        state_reg <= S_EXEC;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_EXEC: begin
                    status_reg <= exec_status;
                    idx_reg <= '0;
                    state_reg <= (cmd_reg.op_known && cmd_reg.op == ssnt_pkg::OP_RESET_ALL) ?
                                 S_CLEAR : S_EMIT;
                    if (cmd_reg.op_known) begin
                        unique case (cmd_reg.op)
                            ssnt_pkg::OP_SELECT: if (cmd_reg.s_ok) begin
                                sel_valid_reg <= 1'b1;
                                sel_index_reg <= cmd_reg.s;
                            end
                            ssnt_pkg::OP_DESELECT: begin
                                sel_valid_reg <= 1'b0;
                                sel_index_reg <= '0;
                            end
                            ssnt_pkg::OP_RESET: if (cmd_reg.s_ok) begin
                                for (int k = 0; k < ssnt_pkg::NOTES; k++) begin
                                    notes_reg[tgt_reg][k] <= '0;
                                end
                                count_reg[tgt_reg] <= '0;
                                gate_reg[tgt_reg] <= dgate;
                                vel_reg[tgt_reg] <= cfg.default_velocity;
                                prob_reg[tgt_reg] <= dprob;
                                tie_reg[tgt_reg] <= 1'b0;
                            end
                            ssnt_pkg::OP_RESET_ALL: begin
                                sel_valid_reg <= 1'b0;
                                sel_index_reg <= '0;
                                clr_reg <= '0;
                            end
                            ssnt_pkg::OP_TOGGLE: if (sel_valid_reg && tok) begin
                                for (int k = 0; k < ssnt_pkg::NOTES; k++) begin
                                    notes_reg[tgt_reg][k] <= trow[k];
                                end
                                count_reg[tgt_reg] <= tcnt;
                            end
                            ssnt_pkg::OP_CLEAR: if (cmd_reg.s_ok) begin
                                for (int k = 0; k < ssnt_pkg::NOTES; k++) begin
                                    notes_reg[tgt_reg][k] <= '0;
                                end
                                count_reg[tgt_reg] <= '0;
                                tie_reg[tgt_reg] <= 1'b0;
                            end
                            ssnt_pkg::OP_COPY: if (cmd_reg.s_ok && cmd_reg.d_ok) begin
                                for (int k = 0; k < ssnt_pkg::NOTES; k++) begin
                                    notes_reg[cmd_reg.d][k] <= row_reg[k];
                                end
                                count_reg[cmd_reg.d] <= rcnt_reg;
                                gate_reg[cmd_reg.d] <= rgate_reg;
                                vel_reg[cmd_reg.d] <= rvel_reg;
                                prob_reg[cmd_reg.d] <= rprob_reg;
                                tie_reg[cmd_reg.d] <= rtie_reg;
                            end
                            ssnt_pkg::OP_GATE:
                                if (cmd_reg.s_ok && rgate_reg != cmd_reg.gate_c) begin
                                    gate_reg[tgt_reg] <= cmd_reg.gate_c;
                                end
                            ssnt_pkg::OP_VELOCITY:
                                if (cmd_reg.s_ok && rvel_reg != cmd_reg.vel_c) begin
                                    vel_reg[tgt_reg] <= cmd_reg.vel_c;
                                end
                            ssnt_pkg::OP_PROBABILITY:
                                if (cmd_reg.s_ok && rprob_reg != cmd_reg.prob_c) begin
                                    prob_reg[tgt_reg] <= cmd_reg.prob_c;
                                end
                            ssnt_pkg::OP_TIE:
                                if (cmd_reg.s_ok && rtie_reg != cmd_reg.tie_c) begin
                                    tie_reg[tgt_reg] <= cmd_reg.tie_c;
                                end
                            ssnt_pkg::OP_TRANSPOSE: begin
                                if (cmd_reg.s_ok && rcnt_reg != '0 && !bad_reg &&
                                    cmd_reg.delta != 16'sd0) begin
                                    for (int k = 0; k < ssnt_pkg::NOTES; k++) begin
                                        if (k < int'(rcnt_reg)) begin
                                            notes_reg[tgt_reg][k] <= row_reg[k] + cmd_reg.delta;
                                        end
                                    end
                                end
                            end
                            ssnt_pkg::OP_READ: begin
                                if (!cmd_reg.s_ok) begin
                                    rcnt_reg <= '0;
                                    rgate_reg <= dgate;
                                    rvel_reg <= cfg.default_velocity;
                                    rprob_reg <= dprob;
                                    rtie_reg <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_EMIT: begin
                    if (emit_go) begin
                        m_data <= emit_data;
                        if (emit_more) begin
                            idx_reg <= idx_reg + 1'b1;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_CLEAR: begin
                    for (int k = 0; k < ssnt_pkg::NOTES; k++) begin
                        notes_reg[clr_reg][k] <= '0;
                    end
                    count_reg[clr_reg] <= '0;
                    gate_reg[clr_reg] <= dgate;
                    vel_reg[clr_reg] <= cfg.default_velocity;
                    prob_reg[clr_reg] <= dprob;
                    tie_reg[clr_reg] <= 1'b0;
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == ssnt_pkg::STEPS - 1) begin
                        state_reg <= init_reg ? S_IDLE : S_EMIT;
                        init_reg <= 1'b0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/step_sequencer_note_table_top.sv
// Flow: each command is queued, loaded, executed and emitted; transpose first checks
// each note of the step in turn, and reset all clears every step in turn before emitting.
// Throughput: one command in flight in the execute unit; a read emits one result per
// cycle while the result side is ready, one per note (one for an empty step). A 2-entry
// queue decouples input, and a waiting result does not hold off the next command.
// Reset: synchronous, active low; afterward a clearing pass loads every step with
// the defaults before the first command is taken.
module step_sequencer_note_table_top (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  ssnt_pkg::in_item_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output ssnt_pkg::out_item_t m_data,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data
);

    ssnt_pkg::cfg_t cfg_reg;
    ssnt_pkg::cmd_t q_cmd;
    logic q_valid, q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cycle_length <= ssnt_pkg::CYCLE_DEFAULT;
            cfg_reg.global_transpose <= 16'sd0;
            cfg_reg.default_gate <= 10'd500;
            cfg_reg.default_velocity <= 7'd100;
            cfg_reg.default_probability <= 7'd100;
        end else if (cfg_we) begin
            priority case (cfg_index)
                ssnt_pkg::REG_CYCLE: cfg_reg.cycle_length <= cfg_data[7:0];
                ssnt_pkg::REG_TRANSPOSE: cfg_reg.global_transpose <= cfg_data;
                ssnt_pkg::REG_GATE: cfg_reg.default_gate <= cfg_data[9:0];
                ssnt_pkg::REG_VEL: cfg_reg.default_velocity <= cfg_data[6:0];
                ssnt_pkg::REG_PROB: cfg_reg.default_probability <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    ssnt_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    ssnt_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule

FILE: tb/step_sequencer_note_table_top_tb.sv
`timescale 1ns / 1ps

module step_sequencer_note_table_top_tb;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        ssnt_pkg::in_item_t   item;
        logic                 has_exp;
        ssnt_pkg::out_item_t  exp_res;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ssnt_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ssnt_pkg::out_item_t m_data;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    step_sequencer_note_table_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // model state
    logic signed [15:0] pitch_tab [ssnt_pkg::STEPS][ssnt_pkg::NOTES];
    int unsigned cnt_tab [ssnt_pkg::STEPS];
    logic [9:0] gate_tab [ssnt_pkg::STEPS];
    logic [6:0] vel_tab [ssnt_pkg::STEPS];
    logic [6:0] prob_tab [ssnt_pkg::STEPS];
    logic tie_tab [ssnt_pkg::STEPS];
    logic sel_on;
    logic [3:0] sel_idx;
    ssnt_pkg::cfg_t cfg_shadow;

    ssnt_pkg::out_item_t expected_q [$];
    int errors = 0;
    int idle_cycles = 0;

    function automatic logic [9:0] def_gate();
        return (cfg_shadow.default_gate > ssnt_pkg::GATE_MAX) ? ssnt_pkg::GATE_MAX
                                                              : cfg_shadow.default_gate;
    endfunction

    function automatic logic [6:0] def_prob();
        return (cfg_shadow.default_probability > ssnt_pkg::PROB_MAX) ? ssnt_pkg::PROB_MAX
                                                           : cfg_shadow.default_probability;
    endfunction

    function automatic void clear_step(int s);
        for (int k = 0; k < ssnt_pkg::NOTES; k++) pitch_tab[s][k] = '0;
        cnt_tab[s] = 0;
        gate_tab[s] = def_gate();
        vel_tab[s] = cfg_shadow.default_velocity;
        prob_tab[s] = def_prob();
        tie_tab[s] = 1'b0;
    endfunction

    function automatic void reset_table();
        for (int s = 0; s < ssnt_pkg::STEPS; s++) clear_step(s);
        sel_on = 1'b0;
        sel_idx = '0;
    endfunction

    function automatic bit octave_in_range(int p);
        int c, dsp, q;
        c = (cfg_shadow.cycle_length == 0) ? 12 : int'(cfg_shadow.cycle_length);
        dsp = p + int'(cfg_shadow.global_transpose);
        q = dsp / c;
        if (dsp % c < 0) q -= 1;
        q += ssnt_pkg::OCT_BASE;
        return q >= 0 && q <= ssnt_pkg::OCT_TOP;
    endfunction

    function automatic ssnt_pkg::out_item_t status_result(ssnt_pkg::status_t st);
        ssnt_pkg::out_item_t r;
        r = '0;
        r.status = st;
        r.selected_valid = sel_on;
        r.selected_index = sel_on ? sel_idx : 4'd0;
        r.last = 1'b1;
        return r;
    endfunction

    // apply one command to the table and queue the results it causes
    function automatic void apply_command(ssnt_pkg::in_item_t it);
        int s, d, n, k, p, dl, t, v, cnt, rn;
        bit ok;
        ssnt_pkg::status_t st;
        ssnt_pkg::out_item_t r;
        logic [9:0] g;
        logic [6:0] vv, pp;
        logic ti;
        s = int'(it.step_index);
        d = int'(it.other_step);
        p = int'(it.pitch);
        dl = int'(it.pitch_delta);
        v = int'(it.setting_value);
        ok = s < ssnt_pkg::STEPS;
        st = ssnt_pkg::ST_REFUSED;
        case (it.opcode)
            ssnt_pkg::OP_SELECT: if (ok) begin
                sel_on = 1'b1; sel_idx = s[3:0]; st = ssnt_pkg::ST_DONE;
            end
            ssnt_pkg::OP_DESELECT: begin
                sel_on = 1'b0; sel_idx = '0; st = ssnt_pkg::ST_DONE;
            end
            ssnt_pkg::OP_RESET: if (ok) begin
                clear_step(s); st = ssnt_pkg::ST_DONE;
            end
            ssnt_pkg::OP_RESET_ALL: begin
                reset_table(); st = ssnt_pkg::ST_DONE;
            end
            ssnt_pkg::OP_TOGGLE: if (sel_on) begin
                t = int'(sel_idx);
                n = cnt_tab[t];
                for (k = 0; k < n; k++) if (pitch_tab[t][k] == p) break;
                if (k < n) begin
                    for (; k + 1 < n; k++) pitch_tab[t][k] = pitch_tab[t][k+1];
                    pitch_tab[t][n-1] = '0;
                    cnt_tab[t] = n - 1;
                    st = ssnt_pkg::ST_DONE;
                end else if (n < ssnt_pkg::NOTES) begin
                    k = n;
                    while (k > 0 && pitch_tab[t][k-1] > p) begin
                        pitch_tab[t][k] = pitch_tab[t][k-1];
                        k--;
                    end
                    pitch_tab[t][k] = 16'(p);
                    cnt_tab[t] = n + 1;
                    st = ssnt_pkg::ST_DONE;
                end
            end
            ssnt_pkg::OP_CLEAR: if (ok) begin
                for (k = 0; k < ssnt_pkg::NOTES; k++) pitch_tab[s][k] = '0;
                cnt_tab[s] = 0; tie_tab[s] = 1'b0; st = ssnt_pkg::ST_DONE;
            end
            ssnt_pkg::OP_COPY: if (ok && d < ssnt_pkg::STEPS) begin
                for (k = 0; k < ssnt_pkg::NOTES; k++) pitch_tab[d][k] = pitch_tab[s][k];
                cnt_tab[d] = cnt_tab[s];
                gate_tab[d] = gate_tab[s];
                vel_tab[d] = vel_tab[s];
                prob_tab[d] = prob_tab[s];
                tie_tab[d] = tie_tab[s];
                st = ssnt_pkg::ST_DONE;
            end
            ssnt_pkg::OP_GATE: if (ok) begin
                g = (v > 1000) ? ssnt_pkg::GATE_MAX : v[9:0];
                if (gate_tab[s] != g) begin gate_tab[s] = g; st = ssnt_pkg::ST_DONE; end
            end
            ssnt_pkg::OP_VELOCITY: if (ok) begin
                vv = (v > 127) ? ssnt_pkg::VEL_MAX : v[6:0];
                if (vel_tab[s] != vv) begin vel_tab[s] = vv; st = ssnt_pkg::ST_DONE; end
            end
            ssnt_pkg::OP_PROBABILITY: if (ok) begin
                pp = (v > 100) ? ssnt_pkg::PROB_MAX : v[6:0];
                if (prob_tab[s] != pp) begin prob_tab[s] = pp; st = ssnt_pkg::ST_DONE; end
            end
            ssnt_pkg::OP_TIE: if (ok) begin
                ti = (v != 0);
                if (tie_tab[s] != ti) begin tie_tab[s] = ti; st = ssnt_pkg::ST_DONE; end
            end
            ssnt_pkg::OP_TRANSPOSE: begin
                if (!ok || cnt_tab[s] == 0) st = ssnt_pkg::ST_EMPTY;
                else begin
                    n = cnt_tab[s];
                    for (k = 0; k < n; k++) begin
                        t = int'(pitch_tab[s][k]) + dl;
                        if (t < -32768 || t > 32767 || !octave_in_range(t))
                            st = ssnt_pkg::ST_RANGE;
                    end
                    if (st != ssnt_pkg::ST_RANGE && dl != 0) begin
                        for (k = 0; k < n; k++)
                            pitch_tab[s][k] = 16'(int'(pitch_tab[s][k]) + dl);
                        st = ssnt_pkg::ST_DONE;
                    end
                end
            end
            ssnt_pkg::OP_READ: begin
                cnt = ok ? cnt_tab[s] : 0;
                rn = cnt ? cnt : 1;
                g = ok ? gate_tab[s] : def_gate();
                vv = ok ? vel_tab[s] : cfg_shadow.default_velocity;
                pp = ok ? prob_tab[s] : def_prob();
                ti = ok ? tie_tab[s] : 1'b0;
                for (k = 0; k < rn; k++) begin
                    r = status_result(ok ? ssnt_pkg::ST_DONE : ssnt_pkg::ST_REFUSED);
                    if (cnt != 0) begin
                        r.note_valid = 1'b1;
                        r.note_pitch = pitch_tab[s][k];
                    end
                    r.note_count = cnt[3:0];
                    r.gate_out = g;
                    r.velocity_out = vv;
                    r.probability_out = pp;
                    r.tie_out = ti;
                    r.programmed = (cnt > 0) || ti;
                    r.last = (k + 1 == rn);
                    expected_q.push_back(r);
                end
                return;
            end
            default: ;
        endcase
        expected_q.push_back(status_result(st));
    endfunction

    // starts and ends one half period apart from any other drive of s_valid
    task automatic send_command(ssnt_pkg::in_item_t it);
        int gap;
        @(negedge aclk);
        gap = $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        apply_command(it);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            ssnt_pkg::REG_CYCLE: cfg_shadow.cycle_length = val[7:0];
            ssnt_pkg::REG_TRANSPOSE: cfg_shadow.global_transpose = val;
            ssnt_pkg::REG_GATE: cfg_shadow.default_gate = val[9:0];
            ssnt_pkg::REG_VEL: cfg_shadow.default_velocity = val[6:0];
            ssnt_pkg::REG_PROB: cfg_shadow.default_probability = val[6:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    function automatic ssnt_pkg::in_item_t make_cmd(ssnt_pkg::op_t op, int s, int d, int p,
                                                    int dl, int v);
        ssnt_pkg::in_item_t it;
        it.opcode = op;
        it.step_index = 8'(s);
        it.other_step = 8'(d);
        it.pitch = 16'(p);
        it.pitch_delta = 16'(dl);
        it.setting_value = 16'(v);
        return it;
    endfunction

    function automatic ssnt_pkg::in_item_t random_cmd();
        ssnt_pkg::in_item_t it;
        it = ssnt_pkg::in_item_t'(68'({$urandom, $urandom, $urandom}));
        // mostly valid steps and small pitches so edits land on real notes
        if ($urandom_range(0, 9) != 0)
            it.step_index = 8'($urandom_range(0, ssnt_pkg::STEPS - 1));
        if ($urandom_range(0, 9) != 0)
            it.other_step = 8'($urandom_range(0, ssnt_pkg::STEPS - 1));
        if ($urandom_range(0, 4) != 0) it.pitch = 16'(int'($urandom_range(0, 40)) - 20);
        if ($urandom_range(0, 3) != 0)
            it.pitch_delta = 16'(int'($urandom_range(0, 24)) - 12);
        case ($urandom_range(0, 19))
            0: it.opcode = ssnt_pkg::OP_RESET_ALL;
            1, 2: it.opcode = ssnt_pkg::OP_SELECT;
            3, 4, 5, 6, 7: it.opcode = ssnt_pkg::OP_TOGGLE;
            8, 9, 10: it.opcode = ssnt_pkg::OP_READ;
            11: it.opcode = 4'($urandom_range(13, 15));
            default: it.opcode = 4'($urandom_range(0, 12));
        endcase
        if (it.opcode == ssnt_pkg::OP_RESET_ALL && $urandom_range(0, 3) != 0)
            it.opcode = ssnt_pkg::OP_READ;
        return it;
    endfunction

    // result side: stall at random, check every transfer
    initial begin
        ssnt_pkg::out_item_t e;
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = $urandom_range(0, 15);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer: %p", m_data);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (m_data.status !== e.status)
                    begin $error("status exp %0d got %0d", e.status, m_data.status); errors++; end
                if (m_data.note_valid !== e.note_valid)
                    begin $error("note_valid exp %0d got %0d", e.note_valid,
                                 m_data.note_valid); errors++; end
                if (m_data.note_pitch !== e.note_pitch)
                    begin $error("note_pitch exp %0d got %0d", e.note_pitch,
                                 m_data.note_pitch); errors++; end
                if (m_data.note_count !== e.note_count)
                    begin $error("note_count exp %0d got %0d", e.note_count,
                                 m_data.note_count); errors++; end
                if (m_data.gate_out !== e.gate_out)
                    begin $error("gate_out exp %0d got %0d", e.gate_out,
                                 m_data.gate_out); errors++; end
                if (m_data.velocity_out !== e.velocity_out)
                    begin $error("velocity_out exp %0d got %0d", e.velocity_out,
                                 m_data.velocity_out); errors++; end
                if (m_data.probability_out !== e.probability_out)
                    begin $error("probability_out exp %0d got %0d", e.probability_out,
                                 m_data.probability_out); errors++; end
                if (m_data.tie_out !== e.tie_out)
                    begin $error("tie_out exp %0d got %0d", e.tie_out,
                                 m_data.tie_out); errors++; end
                if (m_data.programmed !== e.programmed)
                    begin $error("programmed exp %0d got %0d", e.programmed,
                                 m_data.programmed); errors++; end
                if (m_data.selected_valid !== e.selected_valid)
                    begin $error("selected_valid exp %0d got %0d", e.selected_valid,
                                 m_data.selected_valid); errors++; end
                if (m_data.selected_index !== e.selected_index)
                    begin $error("selected_index exp %0d got %0d", e.selected_index,
                                 m_data.selected_index); errors++; end
                if (m_data.last !== e.last)
                    begin $error("last exp %0d got %0d", e.last, m_data.last); errors++; end
            end
        end
    end

    // watchdog: count cycles with no transfer on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("step_sequencer_note_table_top: mismatch");
            $finish;
        end
    end

    initial begin
        stim_row_t rows [$];
        stim_row_t row;
        ssnt_pkg::out_item_t r;
        cfg_shadow = '{cycle_length: ssnt_pkg::CYCLE_DEFAULT, global_transpose: 16'sd0,
                       default_gate: 10'd500, default_velocity: 7'd100,
                       default_probability: 7'd100};
        reset_table();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset read: defaults, empty step
        r = '0; r.gate_out = 10'd500; r.velocity_out = 7'd100; r.probability_out = 7'd100;
        r.last = 1'b1;
        rows.push_back('{make_cmd(ssnt_pkg::OP_READ, 0, 0, 0, 0, 0), 1'b1, r});
        r.status = ssnt_pkg::ST_REFUSED;
        rows.push_back('{make_cmd(ssnt_pkg::OP_READ, 255, 0, 0, 0, 0), 1'b1, r});
        r = '0; r.status = ssnt_pkg::ST_EMPTY; r.last = 1'b1;
        rows.push_back('{make_cmd(ssnt_pkg::OP_TRANSPOSE, 3, 0, 0, 5, 0), 1'b1, r});
        r.status = ssnt_pkg::ST_REFUSED;
        rows.push_back('{make_cmd(ssnt_pkg::OP_TOGGLE, 0, 0, 7, 0, 0), 1'b1, r});
        rows.push_back('{make_cmd(ssnt_pkg::OP_SELECT, 16, 0, 0, 0, 0), 1'b1, r});
        rows.push_back('{make_cmd(ssnt_pkg::op_t'(4'd15), 0, 0, 0, 0, 0), 1'b1, r});
        r = '0; r.last = 1'b1;
        rows.push_back('{make_cmd(ssnt_pkg::OP_DESELECT, 0, 0, 0, 0, 0), 1'b1, r});
        rows.push_back('{make_cmd(ssnt_pkg::OP_SELECT, 15, 0, 0, 0, 0), 1'b0, '0});
        rows.push_back('{make_cmd(ssnt_pkg::OP_TOGGLE, 0, 0, 32767, 0, 0), 1'b0, '0});
        rows.push_back('{make_cmd(ssnt_pkg::OP_TOGGLE, 0, 0, -32768, 0, 0), 1'b0, '0});
        rows.push_back('{make_cmd(ssnt_pkg::OP_TOGGLE, 0, 0, 32767, 0, 0), 1'b0, '0});
        for (int k = 0; k < ssnt_pkg::NOTES + 1; k++)
            rows.push_back('{make_cmd(ssnt_pkg::OP_TOGGLE, 0, 0, 9 - 2 * k, 0, 0), 1'b0, '0});
        rows.push_back('{make_cmd(ssnt_pkg::OP_READ, 15, 0, 0, 0, 0), 1'b0, '0});
        rows.push_back('{make_cmd(ssnt_pkg::OP_TRANSPOSE, 15, 0, 0, 32767, 0), 1'b0, '0});
        rows.push_back('{make_cmd(ssnt_pkg::OP_GATE, 15, 0, 0, 0, 65535), 1'b0, '0});
        rows.push_back('{make_cmd(ssnt_pkg::OP_VELOCITY, 15, 0, 0, 0, 200), 1'b0, '0});
        rows.push_back('{make_cmd(ssnt_pkg::OP_PROBABILITY, 15, 0, 0, 0, 101), 1'b0, '0});
        rows.push_back('{make_cmd(ssnt_pkg::OP_TIE, 15, 0, 0, 0, 65535), 1'b0, '0});
        rows.push_back('{make_cmd(ssnt_pkg::OP_COPY, 15, 2, 0, 0, 0), 1'b0, '0});
        rows.push_back('{make_cmd(ssnt_pkg::OP_READ, 2, 0, 0, 0, 0), 1'b0, '0});

        foreach (rows[i]) begin
            row = rows[i];
            if (row.has_exp) begin
                send_command(row.item);
                if (expected_q[$] !== row.exp_res) begin
                    $error("directed row %0d: exp %p model %p", i, row.exp_res, expected_q[$]);
                    errors++;
                end
            end else
                send_command(row.item);
        end

        wait_drained();
        // extremes of every register, then opposite extremes, defaults and random settings per phase
        write_reg(ssnt_pkg::REG_CYCLE, 16'd0);
        write_reg(ssnt_pkg::REG_TRANSPOSE, 16'h8000);
        write_reg(ssnt_pkg::REG_GATE, 16'h03FF);
        write_reg(ssnt_pkg::REG_VEL, 16'h007F);
        write_reg(ssnt_pkg::REG_PROB, 16'h007F);
        for (int ph = 0; ph < 6; ph++) begin
            for (int i = 0; i < 50; i++) send_command(random_cmd());
            // hold off until everything issued so far has come back
            wait_drained();
            case (ph)
                0: begin
                    write_reg(ssnt_pkg::REG_CYCLE, 16'd255);
                    write_reg(ssnt_pkg::REG_TRANSPOSE, 16'h7FFF);
                    write_reg(ssnt_pkg::REG_GATE, 16'd0);
                    write_reg(ssnt_pkg::REG_VEL, 16'd0);
                    write_reg(ssnt_pkg::REG_PROB, 16'd0);
                end
                1: begin
                    write_reg(ssnt_pkg::REG_CYCLE, 16'd12);
                    write_reg(ssnt_pkg::REG_TRANSPOSE, 16'd0);
                    write_reg(ssnt_pkg::REG_GATE, 16'd500);
                    write_reg(ssnt_pkg::REG_VEL, 16'd100);
                    write_reg(ssnt_pkg::REG_PROB, 16'd100);
                end
                default: begin
                    write_reg(ssnt_pkg::REG_CYCLE, 16'($urandom_range(0, 255)));
                    write_reg(ssnt_pkg::REG_TRANSPOSE, 16'(int'($urandom_range(0, 80)) - 40));
                    write_reg(ssnt_pkg::REG_GATE, 16'($urandom_range(0, 1023)));
                    write_reg(ssnt_pkg::REG_VEL, 16'($urandom_range(0, 127)));
                    write_reg(ssnt_pkg::REG_PROB, 16'($urandom_range(0, 127)));
                end
            endcase
        end
        wait_drained();

        if (errors == 0)
            $display("step_sequencer_note_table_top: match");
        else
            $display("step_sequencer_note_table_top: mismatch");
        $finish;
    end

endmodule
